>>> sv/dereq_pkg.sv
// shared types and constants for the double-ended ring queue
package dereq_pkg;

  localparam int MODE_W = 3;
  localparam int CAP_W  = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [MODE_W-1:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_REAR  = 3'd1,
    MODE_DEL_FRONT = 3'd2,
    MODE_DEL_REAR  = 3'd3,
    MODE_QUERY     = 3'd4
  } mode_t;

  typedef struct packed {
    logic latch_in;
    logic execute;
    logic read;
    logic load_out;
  } cmd_t;

endpackage

>>> sv/dereq_req_if.sv
// request channel: operation code and value to insert
interface dereq_req_if #(
  parameter int DATA_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic [dereq_pkg::MODE_W-1:0]  mode;
  logic signed [DATA_BITS-1:0]   item_value;

  modport source (output valid, output mode, output item_value, input ready);
  modport sink   (input valid, input mode, input item_value, output ready);
endinterface

>>> sv/dereq_rsp_if.sv
// result channel: success flag, end values and fill flags
interface dereq_rsp_if #(
  parameter int DATA_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic signed [DATA_BITS-1:0] head_value;
  logic signed [DATA_BITS-1:0] tail_value;
  logic                        is_empty;
  logic                        is_full;

  modport source (output valid, output accepted, output head_value, output tail_value,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input accepted, input head_value, input tail_value,
                  input is_empty, input is_full, output ready);
endinterface

>>> sv/double_ended_ring_queue.sv
// double-ended ring queue with a capacity register: top level
// steps from request acceptance to result valid: pointer update and memory
//   write, registered dual read, result register load
// a new request is taken only once the last has finished these steps; it
//   is taken while the last result waits
// reset: capacity 16, queue empty; entry memory content undefined, no sweep
module double_ended_ring_queue #(
  parameter int MAX_DEPTH = 16,
  parameter int DATA_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  dereq_req_if.sink                    request,
  dereq_rsp_if.source                  result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [dereq_pkg::CAP_W-1:0]  queue_capacity
);

  dereq_pkg::cmd_t cmd;

  // user must send capacity writes only while idle (not enforced); all taken
  assign cfg_ready = 1'b1;

  // controller owns the handshakes and the step sequence
  dereq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .rsp_valid (result.valid),
    .rsp_ready (result.ready),
    .cmd       (cmd)
  );

  // datapath holds pointers, entries and the result register
  dereq_dpath #(
    .MAX_DEPTH (MAX_DEPTH),
    .DATA_BITS (DATA_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_data     (queue_capacity),
    .in_mode      (request.mode),
    .in_value     (request.item_value),
    .out_accepted (result.accepted),
    .out_head     (result.head_value),
    .out_tail     (result.tail_value),
    .out_empty    (result.is_empty),
    .out_full     (result.is_full)
  );

endmodule

>>> sv/dereq_ctrl.sv
// sequencing controller: request intake, execute, read, result hand-off
module dereq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output dereq_pkg::cmd_t   cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_FIN
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !rsp_valid || rsp_ready;

  always_comb begin
    cmd.latch_in = req_valid && req_ready;
    cmd.execute  = (state == ST_EXEC);
    cmd.read     = (state == ST_READ);
    cmd.load_out = (state == ST_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      req_ready <= 1'b1;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && !cmd.load_out) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_valid && req_ready) begin
            state     <= ST_EXEC;
            req_ready <= 1'b0;
          end
        end
        ST_EXEC: begin
          state <= ST_READ;
        end
        ST_READ: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            state     <= ST_IDLE;
            req_ready <= 1'b1;
            rsp_valid <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/dereq_dpath.sv
// datapath: capacity register, ring pointers, entry memory, result register
module dereq_dpath #(
  parameter int MAX_DEPTH = 16,
  parameter int DATA_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dereq_pkg::cmd_t               cmd,
  input  logic                          cfg_write,
  input  logic [dereq_pkg::CAP_W-1:0]   cfg_data,
  input  logic [dereq_pkg::MODE_W-1:0]  in_mode,
  input  logic signed [DATA_BITS-1:0]   in_value,
  output logic                          out_accepted,
  output logic signed [DATA_BITS-1:0]   out_head,
  output logic signed [DATA_BITS-1:0]   out_tail,
  output logic                          out_empty,
  output logic                          out_full
);

  localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CNT_W = $clog2(MAX_DEPTH + 1);

  logic [dereq_pkg::CAP_W-1:0]  cap_reg;
  logic [CNT_W-1:0]             cap_eff;
  logic [IDX_W-1:0]             head_index, head_next;
  logic [IDX_W-1:0]             tail_index, tail_next;
  logic [CNT_W-1:0]             entry_count, count_next;
  logic [dereq_pkg::MODE_W-1:0] op_mode;
  logic [DATA_BITS-1:0]         op_value;
  logic                         op_ok, ok_next;
  logic                         wr_en;
  logic [IDX_W-1:0]             wr_addr;
  logic [DATA_BITS-1:0]         rd_head, rd_tail;
  logic                         is_full_now, is_empty_now;

  logic [DATA_BITS-1:0] entry_store [MAX_DEPTH];

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] sum;
    sum = CNT_W'(i) + CNT_W'(1);
    return (sum >= cap) ? IDX_W'(0) : IDX_W'(sum);
  endfunction

  function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] top;
    top = cap - CNT_W'(1);
    return (i == IDX_W'(0)) ? IDX_W'(top) : i - IDX_W'(1);
  endfunction

  // zero reads as one, above the ring size saturates
  always_comb begin
    if (cap_reg == '0) begin
      cap_eff = CNT_W'(1);
    end else if (int'(cap_reg) > MAX_DEPTH) begin
      cap_eff = CNT_W'(MAX_DEPTH);
    end else begin
      cap_eff = CNT_W'(cap_reg);
    end
  end

  assign is_full_now  = (entry_count >= cap_eff);
  assign is_empty_now = (entry_count == '0);

  always_comb begin
    head_next  = head_index;
    tail_next  = tail_index;
    count_next = entry_count;
    ok_next    = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = tail_index;
    unique case (op_mode)
      dereq_pkg::MODE_INS_FRONT: begin
        if (!is_full_now) begin
          head_next  = wrap_dec(head_index, cap_eff);
          wr_addr    = head_next;
          wr_en      = 1'b1;
          count_next = entry_count + CNT_W'(1);
          ok_next    = 1'b1;
        end
      end
      dereq_pkg::MODE_INS_REAR: begin
        if (!is_full_now) begin
          wr_addr    = tail_index;
          wr_en      = 1'b1;
          tail_next  = wrap_inc(tail_index, cap_eff);
          count_next = entry_count + CNT_W'(1);
          ok_next    = 1'b1;
        end
      end
      dereq_pkg::MODE_DEL_FRONT: begin
        if (!is_empty_now) begin
          head_next  = wrap_inc(head_index, cap_eff);
          count_next = entry_count - CNT_W'(1);
          ok_next    = 1'b1;
        end
      end
      dereq_pkg::MODE_DEL_REAR: begin
        if (!is_empty_now) begin
          tail_next  = wrap_dec(tail_index, cap_eff);
          count_next = entry_count - CNT_W'(1);
          ok_next    = 1'b1;
        end
      end
      dereq_pkg::MODE_QUERY: begin
        ok_next = 1'b1;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg     <= dereq_pkg::CAP_RESET;
      head_index  <= '0;
      tail_index  <= '0;
      entry_count <= '0;
    end else if (cfg_write) begin
      cap_reg     <= cfg_data;
      head_index  <= '0;
      tail_index  <= '0;
      entry_count <= '0;
    end else if (cmd.execute) begin
      head_index  <= head_next;
      tail_index  <= tail_next;
      entry_count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_mode  <= in_mode;
      op_value <= in_value;
    end
    if (cmd.execute) begin
      op_ok <= ok_next;
    end
  end

  // entry memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.execute && wr_en) begin
      entry_store[wr_addr] <= op_value;
    end
    if (cmd.read) begin
      rd_head <= entry_store[head_index];
      rd_tail <= entry_store[wrap_dec(tail_index, cap_eff)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_accepted <= op_ok;
      out_head     <= is_empty_now ? '1 : rd_head;
      out_tail     <= is_empty_now ? '1 : rd_tail;
      out_empty    <= is_empty_now;
      out_full     <= is_full_now;
    end
  end

endmodule

>>> sim/deque_result_checker.sv
// predicts every deque result from the accepted requests and compares it on arrival
module deque_result_checker #(
  parameter int MAX_DEPTH = 16,
  parameter int DATA_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  dereq_req_if                         request_bus,
  dereq_rsp_if                         result_bus,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [dereq_pkg::CAP_W-1:0]  queue_capacity,
  output int                           pending_results,
  output int                           error_count,
  output int                           results_checked,
  output int                           refused_count
);

  localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  typedef struct packed {
    logic                 accepted;
    logic [DATA_BITS-1:0] head_value;
    logic [DATA_BITS-1:0] tail_value;
    logic                 is_empty;
    logic                 is_full;
  } queue_view_t;

  logic [DATA_BITS-1:0]        ring [MAX_DEPTH];
  logic [dereq_pkg::CAP_W-1:0] capacity_reg;
  int                          head_pos;
  int                          tail_pos;
  int                          fill;
  int                          errors;
  int                          checked;
  int                          refused;
  queue_view_t                 expected_views [$];

  function automatic int ring_size();
    if (capacity_reg == '0) return 1;
    if (capacity_reg > MAX_DEPTH) return MAX_DEPTH;
    return int'(capacity_reg);
  endfunction

  function automatic int step_fwd(int pos, int size);
    return (pos + 1 >= size) ? 0 : pos + 1;
  endfunction

  function automatic int step_back(int pos, int size);
    return (pos == 0) ? size - 1 : pos - 1;
  endfunction

  // applies one operation to the mirrored deque and returns the view after it
  function automatic queue_view_t apply_queue_op(logic [dereq_pkg::MODE_W-1:0] op,
                                                 logic [DATA_BITS-1:0] value);
    queue_view_t view;
    int          size;
    size = ring_size();
    view = '0;
    case (op)
      dereq_pkg::MODE_INS_FRONT: if (fill < size) begin
        head_pos = step_back(head_pos, size);
        ring[IDX_W'(head_pos)] = value;
        fill++;
        view.accepted = 1'b1;
      end
      dereq_pkg::MODE_INS_REAR: if (fill < size) begin
        ring[IDX_W'(tail_pos)] = value;
        tail_pos = step_fwd(tail_pos, size);
        fill++;
        view.accepted = 1'b1;
      end
      dereq_pkg::MODE_DEL_FRONT: if (fill != 0) begin
        head_pos = step_fwd(head_pos, size);
        fill--;
        view.accepted = 1'b1;
      end
      dereq_pkg::MODE_DEL_REAR: if (fill != 0) begin
        tail_pos = step_back(tail_pos, size);
        fill--;
        view.accepted = 1'b1;
      end
      dereq_pkg::MODE_QUERY: view.accepted = 1'b1;
      default: view.accepted = 1'b0;
    endcase
    view.is_empty   = (fill == 0);
    view.is_full    = (fill >= size);
    view.head_value = view.is_empty ? '1 : ring[IDX_W'(head_pos)];
    view.tail_value = view.is_empty ? '1 : ring[IDX_W'(step_back(tail_pos, size))];
    return view;
  endfunction

  always @(posedge clk) begin
    queue_view_t got;
    queue_view_t want;
    if (rst) begin
      capacity_reg = dereq_pkg::CAP_RESET;
      head_pos = 0;
      tail_pos = 0;
      fill = 0;
      errors = 0;
      checked = 0;
      refused = 0;
      expected_views.delete();
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        got = '{result_bus.accepted, result_bus.head_value, result_bus.tail_value,
                result_bus.is_empty, result_bus.is_full};
        if (expected_views.size() == 0) begin
          $error("result arrived with no request outstanding");
          errors++;
        end else begin
          want = expected_views.pop_front();
          checked++;
          if (got.accepted !== want.accepted) begin
            $error("accepted: expected %0b, got %0b", want.accepted, got.accepted);
            errors++;
          end
          if (got.head_value !== want.head_value) begin
            $error("head_value: expected %0d, got %0d",
                   $signed(want.head_value), $signed(got.head_value));
            errors++;
          end
          if (got.tail_value !== want.tail_value) begin
            $error("tail_value: expected %0d, got %0d",
                   $signed(want.tail_value), $signed(got.tail_value));
            errors++;
          end
          if (got.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0b, got %0b", want.is_empty, got.is_empty);
            errors++;
          end
          if (got.is_full !== want.is_full) begin
            $error("is_full: expected %0b, got %0b", want.is_full, got.is_full);
            errors++;
          end
        end
      end
      // a capacity write empties the queue
      if (cfg_valid && cfg_ready) begin
        capacity_reg = queue_capacity;
        head_pos = 0;
        tail_pos = 0;
        fill = 0;
      end
      if (request_bus.valid && request_bus.ready) begin
        want = apply_queue_op(request_bus.mode, request_bus.item_value);
        if (!want.accepted) refused++;
        expected_views.push_back(want);
      end
    end
    pending_results <= expected_views.size();
    error_count     <= errors;
    results_checked <= checked;
    refused_count   <= refused;
  end

endmodule

>>> sim/tb.sv
// request stimulus, result back-pressure and verdict for the double-ended ring queue
module tb;

  localparam int DATA_BITS = 32;
  localparam int PHASE_REQUESTS = 110;
  // operation codes the block does not know, must be refused without effect
  localparam logic [dereq_pkg::MODE_W-1:0] MODE_BAD_FIRST = 3'd5;
  localparam logic [dereq_pkg::MODE_W-1:0] MODE_BAD_MID   = 3'd6;
  localparam logic [dereq_pkg::MODE_W-1:0] MODE_BAD_LAST  = 3'd7;
  localparam logic [DATA_BITS-1:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic [DATA_BITS-1:0] VAL_MIN = 32'h8000_0000;

  typedef enum int {TREND_FILL, TREND_DRAIN, TREND_MIXED} trend_t;
  typedef logic [dereq_pkg::MODE_W-1:0] op_code_t;
  typedef logic [dereq_pkg::CAP_W-1:0]  cap_value_t;

  logic                        clk;
  logic                        rst;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [dereq_pkg::CAP_W-1:0] queue_capacity;
  logic                        rsp_take = 1'b0;
  logic                        steady = 1'b0;
  int                          pending_results;
  int                          error_count;
  int                          results_checked;
  int                          refused_count;
  int                          requests_sent = 0;
  int                          capacity_writes = 0;

  dereq_req_if #(.DATA_BITS(DATA_BITS)) request_bus ();
  dereq_rsp_if #(.DATA_BITS(DATA_BITS)) result_bus ();

  double_ended_ring_queue #(.MAX_DEPTH(16), .DATA_BITS(DATA_BITS)) u_top (
    .clk            (clk),
    .rst            (rst),
    .request        (request_bus),
    .result         (result_bus),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .queue_capacity (queue_capacity)
  );

  deque_result_checker #(.MAX_DEPTH(16), .DATA_BITS(DATA_BITS)) u_checker (
    .clk             (clk),
    .rst             (rst),
    .request_bus     (request_bus),
    .result_bus      (result_bus),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .queue_capacity  (queue_capacity),
    .pending_results (pending_results),
    .error_count     (error_count),
    .results_checked (results_checked),
    .refused_count   (refused_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // result side stalls in roughly one cycle in eight, never during the steady phase
  assign result_bus.ready = rsp_take;
  always @(posedge clk) begin
    rsp_take <= steady || ($urandom_range(99) >= 12);
  end

  // one request: optional idle gap first, then hold valid until the handshake edge
  task automatic push_request(input logic [dereq_pkg::MODE_W-1:0] op,
                              input logic [DATA_BITS-1:0] value);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 12) gap = $urandom_range(1, 6);
    if (gap != 0) begin
      request_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request_bus.valid      <= 1'b1;
    request_bus.mode       <= op;
    request_bus.item_value <= value;
    do @(posedge clk); while (!request_bus.ready);
    requests_sent++;
  endtask

  // drop valid and let every outstanding result come back
  task automatic drain_results();
    request_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  // capacity is only rewritten with the block idle; the write empties the queue
  task automatic write_capacity(input logic [dereq_pkg::CAP_W-1:0] cap);
    drain_results();
    cfg_valid      <= 1'b1;
    queue_capacity <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    capacity_writes++;
  endtask

  // data values lean towards the extremes now and then
  function automatic logic [DATA_BITS-1:0] pick_value();
    case ($urandom_range(9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '1;
      3: return '0;
      default: return $urandom();
    endcase
  endfunction

  // operation mix follows the trend so the queue swings between full and empty
  function automatic logic [dereq_pkg::MODE_W-1:0] pick_op(trend_t trend);
    int   roll;
    logic insert;
    logic front;
    roll = $urandom_range(99);
    if (roll < 4) return op_code_t'($urandom_range(MODE_BAD_FIRST, MODE_BAD_LAST));
    if (roll < 10) return dereq_pkg::MODE_QUERY;
    case (trend)
      TREND_FILL:  insert = (roll < 82);
      TREND_DRAIN: insert = (roll < 28);
      default:     insert = (roll < 55);
    endcase
    front = 1'($urandom_range(1));
    if (insert) return front ? dereq_pkg::MODE_INS_FRONT : dereq_pkg::MODE_INS_REAR;
    return front ? dereq_pkg::MODE_DEL_FRONT : dereq_pkg::MODE_DEL_REAR;
  endfunction

  initial begin
    logic [dereq_pkg::CAP_W-1:0] capacity_plan [10];
    trend_t                      trend;
    int                          left;
    int                          run;

    rst                    = 1'b1;
    cfg_valid              = 1'b0;
    queue_capacity         = dereq_pkg::CAP_RESET;
    request_bus.valid      = 1'b0;
    request_bus.mode       = dereq_pkg::MODE_QUERY;
    request_bus.item_value = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset capacity: empty-queue refusals, unknown codes,
    // extreme values (including one that looks like the empty marker)
    push_request(dereq_pkg::MODE_QUERY, '0);
    push_request(dereq_pkg::MODE_DEL_FRONT, '0);
    push_request(dereq_pkg::MODE_DEL_REAR, '0);
    push_request(MODE_BAD_FIRST, VAL_MAX);
    push_request(MODE_BAD_LAST, '0);
    push_request(dereq_pkg::MODE_INS_FRONT, VAL_MAX);
    push_request(dereq_pkg::MODE_INS_REAR, VAL_MIN);
    push_request(dereq_pkg::MODE_INS_FRONT, '1);
    push_request(dereq_pkg::MODE_INS_REAR, '0);
    push_request(dereq_pkg::MODE_QUERY, VAL_MIN);
    push_request(MODE_BAD_MID, '1);
    push_request(dereq_pkg::MODE_DEL_FRONT, '0);
    push_request(dereq_pkg::MODE_DEL_REAR, '0);
    push_request(dereq_pkg::MODE_DEL_REAR, '0);
    push_request(dereq_pkg::MODE_DEL_FRONT, '0);
    push_request(dereq_pkg::MODE_DEL_FRONT, '0);

    // single-entry ring: insert on full refused, both pointer wraps onto itself
    write_capacity(5'd1);
    push_request(dereq_pkg::MODE_INS_REAR, 32'h5555_5555);
    push_request(dereq_pkg::MODE_INS_FRONT, VAL_MAX);
    push_request(dereq_pkg::MODE_INS_REAR, VAL_MIN);
    push_request(dereq_pkg::MODE_QUERY, '0);
    push_request(dereq_pkg::MODE_DEL_REAR, '0);
    push_request(dereq_pkg::MODE_DEL_REAR, '0);
    push_request(dereq_pkg::MODE_INS_FRONT, 32'haaaa_aaaa);
    push_request(dereq_pkg::MODE_DEL_FRONT, '0);

    // random phases: zero capacity acts as one, oversize values saturate at the depth
    capacity_plan = '{5'd2, 5'd0, 5'd31, 5'd16, 5'd17, 5'd3, 5'd1, 5'd9, 5'd16, 5'd4};
    capacity_plan[8] = cap_value_t'($urandom_range(1, 16));
    foreach (capacity_plan[p]) begin
      write_capacity(capacity_plan[p]);
      steady <= (p == 3);
      left = PHASE_REQUESTS;
      while (left > 0) begin
        trend = trend_t'($urandom_range(2));
        run   = $urandom_range(8, 30);
        while (run > 0 && left > 0) begin
          push_request(pick_op(trend), pick_value());
          run--;
          left--;
        end
      end
    end

    // settle, then wait so that a stray result can still show up
    drain_results();
    repeat (8) @(posedge clk);

    $display("covered %0d requests across %0d capacity writes plus reset value",
             requests_sent, capacity_writes);
    $display("%0d results compared, %0d refused as full, empty or unknown",
             results_checked, refused_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/dereq_pkg.sv
sv/dereq_req_if.sv
sv/dereq_rsp_if.sv
sv/dereq_ctrl.sv
sv/dereq_dpath.sv
sv/double_ended_ring_queue.sv
sim/deque_result_checker.sv
sim/tb.sv
